### rtl/dd_pkg.sv
// Shared types and constants of the deadlock detector.
package dd_pkg;

    localparam int WORK_W  = 13;
    localparam int AMT_W   = 8;
    localparam int IDX_W   = 4;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORK_W-1:0] WORK_MAX = 13'd8191;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        KIND_AVAIL = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_REQ   = 2'd2,
        KIND_START = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] process_index;
        logic [IDX_W-1:0] resource_index;
        logic [AMT_W-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] result_process;
        logic             deadlocked;
        logic             any_deadlock;
        logic             last;
    } t_out_item;

    typedef enum logic [1:0] {
        ALU_ZERO = 2'd0,
        ALU_FIT  = 2'd1,
        ALU_ADD  = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic              flag;
        logic [WORK_W-1:0] sum;
    } t_alu_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ZERO_RD,
        ST_ZERO_EX,
        ST_FIT_PICK,
        ST_FIT_RD,
        ST_FIT_EX,
        ST_REL_RD,
        ST_REL_EX,
        ST_EMIT
    } t_state;

endpackage

### rtl/dd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dd_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                       i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                       o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dd_alu.sv
// Shared compare / saturating add unit, one matrix entry per cycle.
module dd_alu
    import dd_pkg::*;
(
    input  t_alu_op           i_op,
    input  logic [WORK_W-1:0] i_work,
    input  logic [AMT_W-1:0]  i_entry,
    output t_alu_res          o_res
);

    logic [WORK_W:0] sum_wide;

    assign sum_wide = {1'b0, i_work} + (WORK_W + 1)'(i_entry);

    always_comb begin
        o_res.sum  = (sum_wide > {1'b0, WORK_MAX}) ? WORK_MAX : sum_wide[WORK_W-1:0];
        o_res.flag = 1'b0;
        case (i_op)
            ALU_ZERO: o_res.flag = (i_entry == '0);
            ALU_FIT:  o_res.flag = (WORK_W'(i_entry) <= i_work);
            ALU_ADD:  o_res.flag = 1'b1;
            default:  o_res.flag = 1'b0;
        endcase
    end

endmodule

### rtl/deadlock_detector.sv
// Top level of the deadlock detector: sequencer, mark bits and stores.
//
// Usage: an item is transferred when start is high and busy is low.
// Load kinds (available, allocation, request) write one entry in that
// cycle and never raise busy, so loads stream at one per cycle while idle.
// A start item raises busy and runs the detection over process_count rows
// and resource_count columns, set through the write port (i_cfg_we,
// i_cfg_index, i_cfg_data); the user must write them only while the block
// is idle; the block itself does not enforce it. In a start, each matrix
// or work-vector element is a RAM read, then the shared compare/add unit.
// The zero-allocation scan covers every element; each fixed-point pass
// skips marked rows, checks each unmarked row (a failing compare ends the
// row early) and adds each released row's allocation to the work vector;
// at most N+1 passes. Then N results follow, one per cycle, each on
// o_result with o_strobe for one cycle, the last with last set; busy drops
// in the cycle the last result is shown, so the next item may be sent then.
// The receiver cannot stall: results are never held back.
// Reset (synchronous, active low) clears the marks and state and sets both
// counts to 16; the work vector and matrices are not cleared.
module deadlock_detector
    import dd_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int MAX_RES   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    output logic                 o_strobe,
    output t_out_item            o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int PW        = $clog2(MAX_PROCS);
    localparam int RW        = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int CW        = $clog2(MAX_PROCS + 1);
    localparam int RCW       = $clog2(MAX_RES + 1);
    localparam int MAT_DEPTH = MAX_PROCS * (2 ** RW);

    function automatic int clamp_count(logic [CFG_W-1:0] v, int maxv);
        int c;
        c = int'(v);
        if (c < 1) c = 1;
        if (c > maxv) c = maxv;
        return c;
    endfunction

    t_state              r_state, n_state;
    logic [PW-1:0]       r_p, n_p;
    logic [RW-1:0]       r_r, n_r;
    logic                r_acc, n_acc;
    logic                r_progress, n_progress;
    logic                r_any, n_any;
    logic [MAX_PROCS-1:0] r_mark, n_mark;
    logic [CFG_W-1:0]    r_proc_count, r_res_count;
    logic                r_strobe, n_strobe;
    t_out_item           r_out, n_out;

    logic [CW-1:0]       np;
    logic [RCW-1:0]      nr;
    logic                p_last, col_last;
    logic                accept, load_ok, progress_now, dl;
    logic [PW-1:0]       load_p, p_inc;
    logic [RW-1:0]       load_r;

    logic                work_we, alloc_we, req_we;
    logic [RW-1:0]       work_waddr;
    logic [WORK_W-1:0]   work_wdata, work_rdata;
    logic [AMT_W-1:0]    alloc_rdata, req_rdata;
    t_alu_op             alu_op;
    t_alu_res            alu_res;

    assign np = CW'(clamp_count(r_proc_count, MAX_PROCS));
    assign nr = RCW'(clamp_count(r_res_count, MAX_RES));

    assign p_last   = (CW'(r_p) == np - CW'(1));
    assign col_last = (RCW'(r_r) == nr - RCW'(1));
    assign p_inc    = r_p + PW'(1);

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign load_p = PW'(i_item.process_index);
    assign load_r = RW'(i_item.resource_index);
    assign load_ok = (int'(i_item.resource_index) < MAX_RES) &&
                     ((i_item.kind == KIND_AVAIL) ||
                      (int'(i_item.process_index) < MAX_PROCS));

    // a release in this cycle counts as progress for the pass-end decision
    assign progress_now = r_progress || (r_state == ST_REL_EX);
    assign dl = !r_mark[r_p];

    // ---- stores ----
    assign alloc_we = accept && (i_item.kind == KIND_ALLOC) && load_ok;
    assign req_we   = accept && (i_item.kind == KIND_REQ) && load_ok;
    assign work_we  = (accept && (i_item.kind == KIND_AVAIL) && load_ok) ||
                      (r_state == ST_REL_EX);
    assign work_waddr = (r_state == ST_REL_EX) ? r_r : load_r;
    assign work_wdata = (r_state == ST_REL_EX) ? alu_res.sum : WORK_W'(i_item.amount);

    dd_ram #(.W(WORK_W), .D(MAX_RES)) u_work (
        .i_clk   (i_clk),
        .i_we    (work_we),
        .i_waddr (work_waddr),
        .i_wdata (work_wdata),
        .i_raddr (r_r),
        .o_rdata (work_rdata)
    );

    dd_ram #(.W(AMT_W), .D(MAT_DEPTH)) u_alloc (
        .i_clk   (i_clk),
        .i_we    (alloc_we),
        .i_waddr ({load_p, load_r}),
        .i_wdata (i_item.amount),
        .i_raddr ({r_p, r_r}),
        .o_rdata (alloc_rdata)
    );

    dd_ram #(.W(AMT_W), .D(MAT_DEPTH)) u_req (
        .i_clk   (i_clk),
        .i_we    (req_we),
        .i_waddr ({load_p, load_r}),
        .i_wdata (i_item.amount),
        .i_raddr ({r_p, r_r}),
        .o_rdata (req_rdata)
    );

    // ---- shared unit ----
    always_comb begin
        case (r_state)
            ST_FIT_EX: alu_op = ALU_FIT;
            ST_REL_EX: alu_op = ALU_ADD;
            default:   alu_op = ALU_ZERO;
        endcase
    end

    dd_alu u_alu (
        .i_op    (alu_op),
        .i_work  (work_rdata),
        .i_entry ((r_state == ST_FIT_EX) ? req_rdata : alloc_rdata),
        .o_res   (alu_res)
    );

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.kind == KIND_START)) n_state = ST_ZERO_RD;
            end
            ST_ZERO_RD: n_state = ST_ZERO_EX;
            ST_ZERO_EX: begin
                n_state = (col_last && p_last) ? ST_FIT_PICK : ST_ZERO_RD;
            end
            ST_FIT_PICK: begin
                if (!r_mark[r_p]) begin
                    n_state = ST_FIT_RD;
                end else if (p_last && !progress_now) begin
                    n_state = ST_EMIT;
                end
            end
            ST_FIT_RD: n_state = ST_FIT_EX;
            ST_FIT_EX: begin
                if (!alu_res.flag) begin
                    n_state = (p_last && !progress_now) ? ST_EMIT : ST_FIT_PICK;
                end else if (col_last) begin
                    n_state = ST_REL_RD;
                end else begin
                    n_state = ST_FIT_RD;
                end
            end
            ST_REL_RD: n_state = ST_REL_EX;
            ST_REL_EX: begin
                n_state = col_last ? ST_FIT_PICK : ST_REL_RD;
            end
            ST_EMIT: begin
                if (p_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- datapath / outputs ----
    always_comb begin
        n_p        = r_p;
        n_r        = r_r;
        n_acc      = r_acc;
        n_progress = r_progress;
        n_any      = r_any;
        n_mark     = r_mark;
        n_strobe   = 1'b0;
        n_out      = r_out;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.kind == KIND_START)) begin
                    n_p        = '0;
                    n_r        = '0;
                    n_acc      = 1'b1;
                    n_mark     = '0;
                    n_progress = 1'b0;
                end
            end
            ST_ZERO_EX: begin
                if (col_last) begin
                    n_mark[r_p] = r_acc && alu_res.flag;
                    n_p   = p_last ? '0 : p_inc;
                    n_r   = '0;
                    n_acc = 1'b1;
                end else begin
                    n_r   = r_r + RW'(1);
                    n_acc = r_acc && alu_res.flag;
                end
            end
            ST_FIT_PICK: begin
                n_r = '0;
                if (r_mark[r_p]) begin
                    n_p = p_last ? '0 : p_inc;
                    if (p_last) begin
                        n_progress = 1'b0;
                        n_any      = 1'b0;
                    end
                end
            end
            ST_FIT_EX: begin
                if (!alu_res.flag) begin
                    n_r = '0;
                    n_p = p_last ? '0 : p_inc;
                    if (p_last) begin
                        n_progress = 1'b0;
                        n_any      = 1'b0;
                    end
                end else begin
                    n_r = col_last ? '0 : r_r + RW'(1);
                end
            end
            ST_REL_EX: begin
                if (col_last) begin
                    n_mark[r_p] = 1'b1;
                    n_r         = '0;
                    n_p         = p_last ? '0 : p_inc;
                    n_progress  = !p_last;
                end else begin
                    n_r = r_r + RW'(1);
                end
            end
            ST_EMIT: begin
                n_strobe             = 1'b1;
                n_out.result_process = IDX_W'(r_p);
                n_out.deadlocked     = dl;
                n_out.last           = p_last;
                n_out.any_deadlock   = p_last && (r_any || dl);
                n_any                = r_any || dl;
                n_p                  = p_inc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mark       <= '0;
            r_progress   <= 1'b0;
            r_any        <= 1'b0;
            r_strobe     <= 1'b0;
            r_proc_count <= COUNT_RESET;
            r_res_count  <= COUNT_RESET;
        end else begin
            r_state    <= n_state;
            r_mark     <= n_mark;
            r_progress <= n_progress;
            r_any      <= n_any;
            r_strobe   <= n_strobe;
            if (i_cfg_we && (i_cfg_index == CFG_PROCESS_COUNT)) r_proc_count <= i_cfg_data;
            if (i_cfg_we && (i_cfg_index == CFG_RESOURCE_COUNT)) r_res_count <= i_cfg_data;
        end
        r_p   <= n_p;
        r_r   <= n_r;
        r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // ---- checks ----
    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !busy)
        else $error("busy still high with final result");

    a_mid_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy)
        else $error("non-final result while idle");

    a_any_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.any_deadlock) |-> o_result.last)
        else $error("any_deadlock off the final result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.kind == KIND_START)) |=> busy)
        else $error("start transfer did not raise busy");

endmodule
